// ===== hw/rtl/kncal_pkg.sv =====
`default_nettype none

package kncal_pkg;

    localparam int SAMPLE_W = 10;
    localparam int REQ_W    = 2;
    localparam int ROW_W    = 2;
    localparam int COL_W    = 3;
    localparam int WIDE_W   = 16;
    localparam int DIV_CNT_W = $clog2(WIDE_W);

    // full scale after reset, also the minimum every entry holds after reset
    localparam logic [SAMPLE_W-1:0] FS_RESET = SAMPLE_W'(1022);

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_REPORT = 2'd2
    } req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/key_noise_calibrator_core.sv =====
`default_nettype none

// channel | direction | beat contents
// --------+-----------+------------------------------------------------------
// cfg     | in        | cfg_data: full scale reading (10 bits)
// in      | in        | req_type, key_row, key_col, sample_value
// out     | out       | rest_level, min_seen, max_seen, noise_span, snr_ratio
//
// clear and sample beats: accept, then one write of the key entry
// report beats: accept, decode, rest, numerator, 16 restoring divide steps and the output load,
// which waits while the output stalls; arithmetic on one shared 18-bit subtractor
// after reset every entry of the store is swept, in_ready stays low
// cfg beats are taken in every cycle, including during the sweep
// a finished report waits in the output register, the next item is accepted

module key_noise_calibrator_core #(
    parameter int ROWS = 4,
    parameter int COLS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [kncal_pkg::SAMPLE_W-1:0] cfg_data,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [kncal_pkg::REQ_W-1:0]    req_type,
    input  wire logic [kncal_pkg::ROW_W-1:0]    key_row,
    input  wire logic [kncal_pkg::COL_W-1:0]    key_col,
    input  wire logic [kncal_pkg::SAMPLE_W-1:0] sample_value,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [kncal_pkg::WIDE_W-1:0]        rest_level,
    output logic [kncal_pkg::SAMPLE_W-1:0]      min_seen,
    output logic [kncal_pkg::SAMPLE_W-1:0]      max_seen,
    output logic [kncal_pkg::WIDE_W-1:0]        noise_span,
    output logic [kncal_pkg::WIDE_W-1:0]        snr_ratio
);

    import kncal_pkg::*;

    localparam int KEYS  = ROWS * COLS;
    localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int MEM_W = 2 * SAMPLE_W;
    localparam int SUB_W = WIDE_W + 2;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_DECODE,
        S_REST,
        S_NUMER,
        S_DIV,
        S_DONE
    } state_t;

    // entry store: min in the upper half, max in the lower half
    logic [MEM_W-1:0] mem [KEYS];
    logic [MEM_W-1:0] mem_rdata_reg;
    logic             mem_we;
    logic [KEY_W-1:0] mem_waddr;
    logic [MEM_W-1:0] mem_wdata;

    state_t                state_reg, state_next;
    logic [KEY_W-1:0]      sweep_cnt_reg, sweep_cnt_next;
    logic [SAMPLE_W-1:0]   full_scale_reg;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [SAMPLE_W-1:0]   val_reg, val_next;
    logic [WIDE_W-1:0]     noise_reg, noise_next;
    logic [WIDE_W-1:0]     rest_reg, rest_next;
    logic [WIDE_W-1:0]     rem_reg, rem_next;
    logic [WIDE_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;

    logic                  out_valid_reg, out_valid_next;
    logic [WIDE_W-1:0]     rest_level_reg, rest_level_next;
    logic [SAMPLE_W-1:0]   min_seen_reg, min_seen_next;
    logic [SAMPLE_W-1:0]   max_seen_reg, max_seen_next;
    logic [WIDE_W-1:0]     noise_span_reg, noise_span_next;
    logic [WIDE_W-1:0]     snr_ratio_reg, snr_ratio_next;

    // shared subtractor
    logic [SUB_W-1:0] sub_a, sub_b, sub_diff;

    logic                in_accept;
    logic                key_ok;
    logic [KEY_W-1:0]    in_key;
    logic [SAMPLE_W-1:0] cur_min, cur_max;
    logic [SAMPLE_W-1:0] new_min, new_max;
    logic [WIDE_W-1:0]   trial_lo;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;

    assign key_ok = (int'(key_row) < ROWS) && (int'(key_col) < COLS);
    assign in_key = KEY_W'(int'(key_row) * COLS + int'(key_col));

    assign cur_min = mem_rdata_reg[MEM_W-1:SAMPLE_W];
    assign cur_max = mem_rdata_reg[SAMPLE_W-1:0];
    assign new_min = (val_reg < cur_min) ? val_reg : cur_min;
    assign new_max = (val_reg > cur_max) ? val_reg : cur_max;

    assign sub_diff = sub_a - sub_b;
    // low bits of the shifted partial remainder for one divide step
    assign trial_lo = {rem_reg[WIDE_W-2:0], quo_reg[WIDE_W-1]};

    assign out_valid  = out_valid_reg;
    assign rest_level = rest_level_reg;
    assign min_seen   = min_seen_reg;
    assign max_seen   = max_seen_reg;
    assign noise_span = noise_span_reg;
    assign snr_ratio  = snr_ratio_reg;

    // operand select for the shared subtractor
    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        unique case (state_reg)
            S_DECODE:
            begin
                // noise = max - min
                sub_a = SUB_W'(cur_max);
                sub_b = SUB_W'(cur_min);
            end
            S_REST:
            begin
                // rest = max - noise/2
                sub_a = SUB_W'(cur_max);
                sub_b = SUB_W'(noise_reg[WIDE_W-1:1]);
            end
            S_NUMER:
            begin
                // numerator = full scale - rest
                sub_a = SUB_W'(full_scale_reg);
                sub_b = SUB_W'(rest_reg);
            end
            S_DIV:
            begin
                // trial = {rem, next numerator bit} - noise
                sub_a = {1'b0, rem_reg, quo_reg[WIDE_W-1]};
                sub_b = SUB_W'(noise_reg);
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        noise_next      = noise_reg;
        rest_next       = rest_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        rest_level_next = rest_level_reg;
        min_seen_next   = min_seen_reg;
        max_seen_next   = max_seen_reg;
        noise_span_next = noise_span_reg;
        snr_ratio_next  = snr_ratio_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        mem_we          = 1'b0;
        mem_waddr       = key_reg;
        mem_wdata       = '0;

        unique case (state_reg)
            S_SWEEP:
            begin
                // reset pass: every entry to min = reset full scale, max = 0
                mem_we    = 1'b1;
                mem_waddr = sweep_cnt_reg;
                mem_wdata = {FS_RESET, SAMPLE_W'(0)};
                if (sweep_cnt_reg == KEY_W'(KEYS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + KEY_W'(1);
                end
            end
            S_IDLE:
            begin
                // out of range keys and the unused code are dropped here
                if (in_accept && key_ok)
                begin
                    req_next = req_type;
                    key_next = in_key;
                    val_next = sample_value;
                    unique case (req_type)
                        REQ_CLEAR, REQ_SAMPLE, REQ_REPORT: state_next = S_DECODE;
                        default:                           state_next = S_IDLE;
                    endcase
                end
            end
            S_DECODE:
            begin
                unique case (req_reg)
                    REQ_CLEAR:
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = {full_scale_reg, SAMPLE_W'(0)};
                        state_next = S_IDLE;
                    end
                    REQ_SAMPLE:
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = {new_min, new_max};
                        state_next = S_IDLE;
                    end
                    REQ_REPORT:
                    begin
                        noise_next = (sub_diff[WIDE_W-1:0] == '0) ? WIDE_W'(1)
                                                                  : sub_diff[WIDE_W-1:0];
                        state_next = S_REST;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_REST:
            begin
                rest_next  = sub_diff[WIDE_W-1:0];
                state_next = S_NUMER;
            end
            S_NUMER:
            begin
                quo_next     = sub_diff[WIDE_W-1:0];
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                // restoring step, borrow in the top bit means the trial failed
                if (sub_diff[SUB_W-1])
                begin
                    rem_next = trial_lo;
                end
                else
                begin
                    rem_next = sub_diff[WIDE_W-1:0];
                end
                quo_next     = {quo_reg[WIDE_W-2:0], !sub_diff[SUB_W-1]};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == '1)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    rest_level_next = rest_reg;
                    min_seen_next   = cur_min;
                    max_seen_next   = cur_max;
                    noise_span_next = noise_reg;
                    snr_ratio_next  = quo_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            sweep_cnt_reg  <= '0;
            full_scale_reg <= FS_RESET;
            req_reg        <= '0;
            key_reg        <= '0;
            val_reg        <= '0;
            noise_reg      <= '0;
            rest_reg       <= '0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            rest_level_reg <= '0;
            min_seen_reg   <= '0;
            max_seen_reg   <= '0;
            noise_span_reg <= '0;
            snr_ratio_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                full_scale_reg <= cfg_data;
            end
            req_reg        <= req_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            noise_reg      <= noise_next;
            rest_reg       <= rest_next;
            rem_reg        <= rem_next;
            quo_reg        <= quo_next;
            div_cnt_reg    <= div_cnt_next;
            out_valid_reg  <= out_valid_next;
            rest_level_reg <= rest_level_next;
            min_seen_reg   <= min_seen_next;
            max_seen_reg   <= max_seen_next;
            noise_span_reg <= noise_span_next;
            snr_ratio_reg  <= snr_ratio_next;
        end
    end

    // entry store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept)
        begin
            mem_rdata_reg <= mem[in_key];
        end
    end

    // no item is taken while the reset pass runs
    a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> !in_ready)
        else $error("input taken during store sweep");

    // noise is never zero on a delivered result
    a_noise_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (noise_span != '0))
        else $error("zero noise span delivered");

    // rest level agrees with max and noise on every delivered result
    a_rest_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rest_level == WIDE_W'(WIDE_W'(max_seen) - (noise_span >> 1))))
        else $error("rest level inconsistent with max and noise");

    // the last divide step always hands over to the output stage
    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_cnt_reg == '1) |=> (state_reg == S_DONE))
        else $error("divide did not finish after its last step");

endmodule

`default_nettype wire

// ===== test/tb_key_noise_calibrator_core.sv =====
`default_nettype none

module tb_key_noise_calibrator_core;

    timeunit 1ns;
    timeprecision 1ps;

    import kncal_pkg::*;

    // matrix size, kept at the block's defaults
    localparam int KEY_ROWS = 4;
    localparam int KEY_COLS = 8;
    localparam int NUM_KEYS = KEY_ROWS * KEY_COLS;

    // request code that the block must drop without any effect
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // wait well past the end of any report, clear or sample
    // before touching full scale or ending the run
    localparam int DRAIN_CYCLES = 40;
    // cycles without any beat on any channel before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1850;

    // one predicted report beat
    typedef struct packed {
        logic [WIDE_W-1:0]   rest;
        logic [SAMPLE_W-1:0] lowest;
        logic [SAMPLE_W-1:0] highest;
        logic [WIDE_W-1:0]   noise;
        logic [WIDE_W-1:0]   snr;
    } key_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [SAMPLE_W-1:0]   cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [REQ_W-1:0]      req_type;
    logic [ROW_W-1:0]      key_row;
    logic [COL_W-1:0]      key_col;
    logic [SAMPLE_W-1:0]   sample_value;
    logic                  out_valid;
    logic                  out_ready;
    logic [WIDE_W-1:0]     rest_level;
    logic [SAMPLE_W-1:0]   min_seen;
    logic [SAMPLE_W-1:0]   max_seen;
    logic [WIDE_W-1:0]     noise_span;
    logic [WIDE_W-1:0]     snr_ratio;

    // shadow of the block: per-key extremes and the full scale register
    logic [SAMPLE_W-1:0]   shadow_min [NUM_KEYS];
    logic [SAMPLE_W-1:0]   shadow_max [NUM_KEYS];
    logic [SAMPLE_W-1:0]   shadow_full_scale;

    key_report_t           pending_reports[$];
    int                    mismatches;
    int                    items_sent;
    int                    idle_cycles;
    // set by the stimulus to run a stretch with no idling on either side
    bit                    no_idle;

    key_noise_calibrator_core #(
        .ROWS (KEY_ROWS),
        .COLS (KEY_COLS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .key_row      (key_row),
        .key_col      (key_col),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rest_level   (rest_level),
        .min_seen     (min_seen),
        .max_seen     (max_seen),
        .noise_span   (noise_span),
        .snr_ratio    (snr_ratio)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // fold one accepted request into the shadow state; a report also queues
    // the beat the block must produce for it
    function automatic void predict_calibration(
        input logic [REQ_W-1:0]    kind,
        input logic [ROW_W-1:0]    row,
        input logic [COL_W-1:0]    col,
        input logic [SAMPLE_W-1:0] value
    );
        int          k;
        logic [15:0] lo;
        logic [15:0] hi;
        key_report_t r;
        // keys outside the matrix leave everything untouched
        if (int'(row) >= KEY_ROWS || int'(col) >= KEY_COLS)
            return;
        k = int'(row) * KEY_COLS + int'(col);
        case (kind)
            REQ_CLEAR:
            begin
                shadow_min[k] = shadow_full_scale;
                shadow_max[k] = '0;
            end
            REQ_SAMPLE:
            begin
                if (value < shadow_min[k])
                    shadow_min[k] = value;
                if (value > shadow_max[k])
                    shadow_max[k] = value;
            end
            REQ_REPORT:
            begin
                lo = 16'(shadow_min[k]);
                hi = 16'(shadow_max[k]);
                // all of this wraps at 16 bits, also when min is above max
                r.noise = hi - lo;
                if (r.noise == 16'd0)
                    r.noise = 16'd1;
                r.rest = hi - (r.noise >> 1);
                r.snr = (16'(shadow_full_scale) - r.rest) / r.noise;
                r.lowest = shadow_min[k];
                r.highest = shadow_max[k];
                pending_reports.push_back(r);
            end
            default:
            begin
                // unused code, dropped by the block
            end
        endcase
    endfunction

    // one request beat: random gap, then hold valid until accepted
    task automatic send_request(
        input logic [REQ_W-1:0]    kind,
        input logic [ROW_W-1:0]    row,
        input logic [COL_W-1:0]    col,
        input logic [SAMPLE_W-1:0] value
    );
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        req_type     <= kind;
        key_row      <= row;
        key_col      <= col;
        sample_value <= value;
        do
            @(posedge clk);
        while (!in_ready);
        predict_calibration(kind, row, col, value);
        items_sent++;
    endtask

    // drop valid, wait for every queued report, then let any trailing
    // clear or sample finish its entry write
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // full scale write, only while the block is idle
    task automatic write_full_scale(input logic [SAMPLE_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_full_scale = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // reading drawn around a base level, clamped to the converter range
    function automatic logic [SAMPLE_W-1:0] noisy_reading(input int base, input int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return SAMPLE_W'(v);
    endfunction

    // fresh entries: min above max, so every formula wraps
    task automatic test_after_reset();
        send_request(REQ_REPORT, 2'd0, 3'd0, 10'd0);
        send_request(REQ_REPORT, 2'd3, 3'd7, 10'd1023);
        send_request(REQ_REPORT, 2'd2, 3'd4, 10'd0);
    endtask

    // readings at both ends of the range and a flat key with zero noise
    task automatic test_sample_extremes();
        send_request(REQ_SAMPLE, 2'd0, 3'd0, 10'd0);
        send_request(REQ_SAMPLE, 2'd0, 3'd0, 10'd1023);
        send_request(REQ_REPORT, 2'd0, 3'd0, 10'd0);
        send_request(REQ_SAMPLE, 2'd1, 3'd2, 10'd512);
        send_request(REQ_REPORT, 2'd1, 3'd2, 10'd0);
        send_request(REQ_SAMPLE, 2'd1, 3'd3, 10'd1023);
        send_request(REQ_REPORT, 2'd1, 3'd3, 10'd0);
    endtask

    // clear restores the fresh entry; the unused code must change nothing
    task automatic test_clear_and_unused();
        send_request(REQ_CLEAR, 2'd0, 3'd0, 10'd1023);
        send_request(REQ_REPORT, 2'd0, 3'd0, 10'd0);
        send_request(REQ_UNUSED, 2'd2, 3'd5, 10'd1023);
        send_request(REQ_REPORT, 2'd2, 3'd5, 10'd0);
        send_request(REQ_UNUSED, 2'd1, 3'd2, 10'd0);
        send_request(REQ_REPORT, 2'd1, 3'd2, 10'd0);
    endtask

    // full scale at both extremes: clear value and snr numerator follow it
    task automatic test_full_scale_extremes();
        write_full_scale(10'd0);
        send_request(REQ_CLEAR, 2'd3, 3'd7, 10'd0);
        send_request(REQ_REPORT, 2'd3, 3'd7, 10'd0);
        send_request(REQ_SAMPLE, 2'd3, 3'd7, 10'd1023);
        send_request(REQ_REPORT, 2'd3, 3'd7, 10'd0);
        write_full_scale(10'd1023);
        send_request(REQ_CLEAR, 2'd3, 3'd6, 10'd0);
        send_request(REQ_REPORT, 2'd3, 3'd6, 10'd0);
        send_request(REQ_SAMPLE, 2'd3, 3'd6, 10'd1023);
        send_request(REQ_REPORT, 2'd3, 3'd6, 10'd0);
    endtask

    // mostly calibration bursts on one key: optional clear, a run of
    // readings around a rest level, then a report; the rest is stray beats
    task automatic run_phase(input logic [SAMPLE_W-1:0] full_scale, input int count);
        int               start;
        int               base;
        int               spread;
        int               reads;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        write_full_scale(full_scale);
        start = items_sent;
        while (items_sent - start < count)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                send_request(REQ_W'($urandom_range(0, 3)), ROW_W'($urandom),
                             COL_W'($urandom), SAMPLE_W'($urandom));
            end
            else
            begin
                row = ROW_W'($urandom);
                col = COL_W'($urandom);
                if ($urandom_range(0, 3) != 0)
                    send_request(REQ_CLEAR, row, col, SAMPLE_W'($urandom));
                base = $urandom_range(0, 1023);
                case ($urandom_range(0, 3))
                    0: spread = 0;
                    1: spread = 8;
                    2: spread = 64;
                    default: spread = 1023;
                endcase
                reads = $urandom_range(0, 12);
                repeat (reads)
                    send_request(REQ_SAMPLE, row, col, noisy_reading(base, spread));
                send_request(REQ_REPORT, row, col, SAMPLE_W'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    // several full scale settings, extremes and the reset value among them
    task automatic test_random();
        int share;
        share = RANDOM_ITEMS / 5;
        run_phase(SAMPLE_W'($urandom), share);
        run_phase(10'd1023, share);
        run_phase(10'd0, share);
        run_phase(SAMPLE_W'($urandom), share);
        run_phase(FS_RESET, share);
    endtask

    // result side: sometimes ready waits on valid, sometimes it is already up
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            @(negedge clk);
            if (stall == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                do
                    @(posedge clk);
                while (!out_valid);
                repeat (stall - 1)
                    @(posedge clk);
                @(negedge clk);
                out_ready <= 1'b1;
            end
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    // every report beat against the oldest prediction
    always @(posedge clk)
    begin : report_check
        key_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("report beat with nothing pending: rest %0d min %0d max %0d",
                             rest_level, min_seen, max_seen);
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("rest_level", want.rest, rest_level);
                compare_field("min_seen", 16'(want.lowest), 16'(min_seen));
                compare_field("max_seen", 16'(want.highest), 16'(max_seen));
                compare_field("noise_span", want.noise, noise_span);
                compare_field("snr_ratio", want.snr, snr_ratio);
            end
        end
    end

    // hang detector: any beat on any channel restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("no beat for %0d cycles", HANG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int k;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        req_type     = REQ_CLEAR;
        key_row      = '0;
        key_col      = '0;
        sample_value = '0;
        mismatches   = 0;
        items_sent   = 0;
        idle_cycles  = 0;
        no_idle      = 1'b0;
        shadow_full_scale = FS_RESET;
        for (k = 0; k < NUM_KEYS; k++)
        begin
            shadow_min[k] = FS_RESET;
            shadow_max[k] = '0;
        end
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_sample_extremes();
        test_clear_and_unused();
        test_full_scale_extremes();
        test_random();

        settle();
        if (pending_reports.size() != 0)
        begin
            $display("%0d reports never arrived", pending_reports.size());
            mismatches += pending_reports.size();
        end
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/kncal_pkg.sv
hw/rtl/key_noise_calibrator_core.sv
test/tb_key_noise_calibrator_core.sv
